// ===== rtl/core/ara_pkg.sv =====
// Package: shared types, constants and register codes for the range allocator.
package ara_pkg;

  localparam int MaxRanges = 16;
  localparam int IdxW = $clog2(MaxRanges);
  localparam int CntW = $clog2(MaxRanges + 1);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOSPACE = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_WINDOW_BASE = 1'b0,
    REG_WINDOW_SIZE = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] length;
  } range_t;

  // Control broadcast to every cell.
  typedef struct packed {
    logic   rotate;
    logic   insert_shift;
    range_t new_range;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/ara_if.sv =====
// Valid/ready channel interface used for request and result transactions.
interface ara_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] request_base;
  logic [63:0] request_size;
  logic [63:0] alignment;
  modport source (output valid, kind, request_base, request_size, alignment, input ready);
  modport sink (input valid, kind, request_base, request_size, alignment, output ready);
endinterface

interface ara_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] assigned_base;
  modport source (output valid, status, assigned_base, input ready);
  modport sink (input valid, status, assigned_base, output ready);
endinterface

// ===== rtl/core/aligned_range_allocator.sv =====
// Top level: first-fit aligned address range allocator.
// One request at a time. The stored ranges sit in a ring of cells and are
// examined one per cycle at the ring head. A claim rotates the ring once
// to check overlap and find its slot, then inserts. An allocation rotates
// once to walk the gaps and once more to find the slot of the chosen start.
// The result is held in an output register until taken.
module aligned_range_allocator (
  input  logic        clk,
  input  logic        rst,
  ara_req_if.sink     req,
  ara_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  localparam int IW = ara_pkg::IdxW;
  localparam int CW = ara_pkg::CntW;

  logic [63:0] window_base, window_size;
  ara_pkg::state_t state, state_next;
  logic [CW-1:0] count, step;
  logic [IW-1:0] slot;
  logic        kind;
  logic [63:0] rbase, size, align_m1, cand, wend;
  logic        found, hit;
  logic [1:0]  status;
  logic [63:0] granted;
  ara_pkg::cell_ctrl_t ctrl;
  ara_pkg::range_t head;

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[3])
      ara_pkg::REG_WINDOW_BASE: prdata = window_base;
      default:                  prdata = window_size;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base <= '0;
      window_size <= '0;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      if (paddr[3] == ara_pkg::REG_WINDOW_BASE) window_base <= pwdata;
      else window_size <= pwdata;
    end
  end

  ara_chain u_chain (
    .clk   (clk),
    .ctrl  (ctrl),
    .slot  (slot),
    .count (count),
    .head  (head)
  );

  logic [63:0] head_end, gend, next_cand;
  logic        in_table, fits, slot_adv;
  assign in_table = step < count;
  assign head_end = head.start + head.length;
  always_comb begin
    gend = in_table ? head.start : wend;
    if (gend > wend) gend = wend;
    next_cand = (head_end + align_m1) & ~align_m1;
  end
  assign fits = (cand + size) <= gend;

  always_comb begin
    state_next = state;
    ctrl.rotate = 1'b0;
    ctrl.insert_shift = 1'b0;
    ctrl.new_range.start = kind ? rbase : cand;
    ctrl.new_range.length = size;
    req.ready = 1'b0;
    unique case (state)
      ara_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) state_next = ara_pkg::S_SCAN;
      end
      ara_pkg::S_SCAN: begin
        if (size == '0) begin
          state_next = ara_pkg::S_DONE;
        end else if (kind) begin
          if (in_table) ctrl.rotate = 1'b1;
          else state_next = ara_pkg::S_SHIFT;
        end else if (found || fits) begin
          if (in_table) ctrl.rotate = 1'b1;
          else state_next = ara_pkg::S_PLACE;
        end else if (in_table) begin
          ctrl.rotate = 1'b1;
        end else begin
          state_next = ara_pkg::S_DONE;
        end
      end
      ara_pkg::S_PLACE: begin
        if (in_table) ctrl.rotate = 1'b1;
        else state_next = ara_pkg::S_SHIFT;
      end
      ara_pkg::S_SHIFT: begin
        ctrl.insert_shift = ~hit && (count < CW'(ara_pkg::MaxRanges));
        state_next = ara_pkg::S_DONE;
      end
      default: begin
        if (!rsp.valid) state_next = ara_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ara_pkg::S_IDLE;
    else state <= state_next;
  end

  // slot counts stored ranges below the new start, compared as each passes.
  assign slot_adv = kind ? (head.start < rbase) : (head.start < cand);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      if (ctrl.insert_shift) count <= count + 1'b1;
      if (state == ara_pkg::S_SHIFT || (state == ara_pkg::S_SCAN &&
          state_next == ara_pkg::S_DONE)) rsp.valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ara_pkg::S_IDLE: begin
        kind <= req.kind;
        rbase <= req.request_base;
        size <= req.request_size;
        align_m1 <= (req.alignment == '0 ? req.request_size : req.alignment) - 64'd1;
        cand <= (window_base + ((req.alignment == '0 ? req.request_size : req.alignment)
                 - 64'd1)) & ~((req.alignment == '0 ? req.request_size : req.alignment)
                 - 64'd1);
        wend <= window_base + window_size;
        step <= '0;
        slot <= '0;
        found <= 1'b0;
        hit <= 1'b0;
      end
      ara_pkg::S_SCAN: begin
        if (ctrl.rotate) step <= step + 1'b1;
        else if (state_next == ara_pkg::S_PLACE) step <= '0;
        if (kind) begin
          if (in_table && rbase < head_end && head.start < rbase + size) hit <= 1'b1;
          if (slot_adv && in_table) slot <= slot + 1'b1;
        end else if (!found) begin
          if (fits) begin
            found <= 1'b1;
          end else if (in_table && head_end > cand) begin
            cand <= next_cand;
          end
        end
      end
      ara_pkg::S_PLACE: begin
        if (ctrl.rotate) step <= step + 1'b1;
        if (slot_adv && in_table) slot <= slot + 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (size == '0) begin
      status = ara_pkg::ST_OK;
      granted = kind ? rbase : '0;
    end else if (kind && hit) begin
      status = ara_pkg::ST_OVERLAP;
      granted = '0;
    end else if (!kind && !found && !fits) begin
      status = ara_pkg::ST_NOSPACE;
      granted = '0;
    end else if (count >= CW'(ara_pkg::MaxRanges)) begin
      status = ara_pkg::ST_FULL;
      granted = '0;
    end else begin
      status = ara_pkg::ST_OK;
      granted = kind ? rbase : cand;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ara_pkg::S_SHIFT || (state == ara_pkg::S_SCAN &&
        state_next == ara_pkg::S_DONE)) begin
      rsp.status <= status;
      rsp.assigned_base <= granted;
    end
  end
endmodule

// ===== rtl/core/ara_cell.sv =====
// One table cell: holds one range and passes it to its neighbor on rotate or insert.
module ara_cell (
  input  logic               clk,
  input  ara_pkg::cell_ctrl_t ctrl,
  input  logic               is_slot,
  input  ara_pkg::range_t    from_prev,
  output ara_pkg::range_t    value
);
  always_ff @(posedge clk) begin
    if (ctrl.rotate) begin
      value <= from_prev;
    end else if (ctrl.insert_shift) begin
      if (is_slot) begin
        value <= ctrl.new_range;
      end else begin
        value <= from_prev;
      end
    end
  end
endmodule

// ===== rtl/core/ara_chain.sv =====
// Row of cells forming a ring; cell 0 is the head presented to the controller.
module ara_chain (
  input  logic                clk,
  input  ara_pkg::cell_ctrl_t ctrl,
  input  logic [ara_pkg::IdxW-1:0] slot,
  input  logic [ara_pkg::CntW-1:0] count,
  output ara_pkg::range_t     head
);
  localparam int IW = ara_pkg::IdxW;
  localparam int CW = ara_pkg::CntW;

  ara_pkg::range_t cells [ara_pkg::MaxRanges];
  ara_pkg::range_t prevs [ara_pkg::MaxRanges];

  // Rotate: the count stored cells move toward index 0 (last stored takes head).
  // Insert: slot takes new range; cells above slot up to count take cell below; others hold.
  for (genvar i = 0; i < ara_pkg::MaxRanges; i++) begin : g_cell
    logic below;
    logic use_slot;
    logic last;
    assign below = (CW'(i) < {1'b0, slot});
    assign use_slot = (IW'(i) == slot);
    assign last = (CW'(i + 1) == count);
    always_comb begin
      if (ctrl.rotate) begin
        prevs[i] = last ? cells[0] : cells[(i + 1) % ara_pkg::MaxRanges];
      end else if (below || CW'(i) > count) begin
        prevs[i] = cells[i];
      end else begin
        prevs[i] = cells[(i + ara_pkg::MaxRanges - 1) % ara_pkg::MaxRanges];
      end
    end
    ara_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .is_slot   (use_slot),
      .from_prev (prevs[i]),
      .value     (cells[i])
    );
  end

  assign head = cells[0];
endmodule

// ===== rtl/core/ara_checker.sv =====
// Port-level checker for the range allocator, bound to the top level.
module ara_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic [1:0] rsp_status,
  input logic [63:0] rsp_base,
  input logic pready
);
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready) else $error("accept while busy");
  a_no_rsp_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("ready while result pending");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ara_pkg::ST_OK |-> rsp_base == 64'd0)
    else $error("failure base");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_base)) else $error("drop");
  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind aligned_range_allocator ara_checker u_ara_checker (
  .clk (clk), .rst (rst),
  .req_valid (req.valid), .req_ready (req.ready),
  .rsp_valid (rsp.valid), .rsp_ready (rsp.ready),
  .rsp_status (rsp.status), .rsp_base (rsp.assigned_base),
  .pready (pready)
);

// ===== tb/aligned_range_allocator_test.sv =====
// Testbench for the aligned range allocator: directed and random requests against a predictor.
`timescale 1ns / 1ps
module aligned_range_allocator_test;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  ara_req_if req ();
  ara_rsp_if rsp ();

  aligned_range_allocator dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct packed {
    ara_pkg::status_t status;
    logic [63:0]      base;
  } grant_t;

  // Shadow allocator state
  logic [63:0] win_base;
  logic [63:0] win_size;
  logic [63:0] shadow_start [ara_pkg::MaxRanges];
  logic [63:0] shadow_len [ara_pkg::MaxRanges];
  int          shadow_count;

  grant_t      pending_grants[$];
  int          errors;
  int          sent;
  int          received;
  int          claims_ok;
  int          allocs_ok;
  int          rejects;
  longint      cycles;
  bit          rsp_hold;
  bit          busy_phase;
  int          idle_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3000000) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] round_to(logic [63:0] x, logic [63:0] a);
    return (x + a - 64'd1) & ~(a - 64'd1);
  endfunction

  function automatic bit overlaps_any(logic [63:0] b, logic [63:0] s);
    for (int i = 0; i < shadow_count; i++)
      if (b < shadow_start[i] + shadow_len[i] && shadow_start[i] < b + s) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit store_range(logic [63:0] b, logic [63:0] s);
    int at;
    if (shadow_count >= ara_pkg::MaxRanges) return 1'b0;
    at = 0;
    while (at < shadow_count && shadow_start[at] < b) at++;
    for (int j = shadow_count; j > at; j--) begin
      shadow_start[j] = shadow_start[j-1];
      shadow_len[j] = shadow_len[j-1];
    end
    shadow_start[at] = b;
    shadow_len[at] = s;
    shadow_count++;
    return 1'b1;
  endfunction

  function automatic grant_t predict_grant(logic k, logic [63:0] b, logic [63:0] s,
                                           logic [63:0] a);
    grant_t      g;
    logic [63:0] cand, wend, gend, nxt;
    bit          done;
    g.status = ara_pkg::ST_OK;
    g.base = '0;
    done = 1'b0;
    if (k) begin
      if (s == 0) g.base = b;
      else if (overlaps_any(b, s)) g.status = ara_pkg::ST_OVERLAP;
      else if (!store_range(b, s)) g.status = ara_pkg::ST_FULL;
      else g.base = b;
    end else if (s != 0) begin
      if (a == 0) a = s;
      cand = round_to(win_base, a);
      wend = win_base + win_size;
      g.status = ara_pkg::ST_NOSPACE;
      for (int i = 0; i <= shadow_count && !done; i++) begin
        gend = (i < shadow_count) ? shadow_start[i] : wend;
        if (gend > wend) gend = wend;
        if (cand + s <= gend) begin
          done = 1'b1;
          if (store_range(cand, s)) begin
            g.status = ara_pkg::ST_OK;
            g.base = cand;
          end else begin
            g.status = ara_pkg::ST_FULL;
          end
        end else if (i < shadow_count) begin
          nxt = shadow_start[i] + shadow_len[i];
          if (nxt > cand) cand = round_to(nxt, a);
        end
      end
    end
    return g;
  endfunction

  // Result checker and receiver stall
  always @(posedge clk) begin
    grant_t g;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        received++;
        if (pending_grants.size() == 0) begin
          $error("unexpected result status=%0d base=%h", rsp.status, rsp.assigned_base);
          errors++;
        end else begin
          g = pending_grants.pop_front();
          if (rsp.status !== g.status) begin
            $error("status expected %0d actual %0d", g.status, rsp.status);
            errors++;
          end
          if (rsp.assigned_base !== g.base) begin
            $error("assigned_base expected %h actual %h", g.base, rsp.assigned_base);
            errors++;
          end
        end
      end
      rsp.ready <= !rsp_hold && ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic write_reg(ara_pkg::reg_index_t idx, logic [63:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 4'(idx) << 3; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == ara_pkg::REG_WINDOW_BASE) win_base = v;
    else win_size = v;
  endtask

  task automatic send_request(logic k, logic [63:0] b, logic [63:0] s, logic [63:0] a);
    @(posedge clk);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    req.valid <= 1'b1; req.kind <= k; req.request_base <= b;
    req.request_size <= s; req.alignment <= a;
    do @(posedge clk); while (!req.ready);
    pending_grants.push_back(predict_grant(k, b, s, a));
    sent++;
    req.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Empties the table by resetting is not allowed; instead fresh phases start full windows
  task automatic set_window(logic [63:0] b, logic [63:0] s);
    drain();
    write_reg(ara_pkg::REG_WINDOW_BASE, b);
    write_reg(ara_pkg::REG_WINDOW_SIZE, s);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    set_window(64'h0, 64'h0);
    send_request(1'b0, 64'h0, 64'h10, 64'h0);
    send_request(1'b1, 64'h1234, 64'h0, 64'h0);
    send_request(1'b0, 64'hFFFF, 64'h0, 64'h8);
    set_window(64'h1000, 64'h1000);
    send_request(1'b0, rand64(), 64'h100, 64'h0);
    send_request(1'b0, 64'h0, 64'h10, 64'h40);
    send_request(1'b0, 64'h0, 64'h30, 64'h3);
    send_request(1'b1, 64'h1000, 64'h8, 64'h0);
    send_request(1'b1, 64'h3000, 64'h100, 64'h0);
    send_request(1'b0, 64'h0, 64'h2000, 64'h0);
    send_request(1'b1, 64'hFFFF_FFFF_FFFF_FFF0, 64'h10, 64'h0);
    send_request(1'b1, 64'hFFFF_FFFF_FFFF_FFF8, 64'h8, 64'h0);
    send_request(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    set_window(64'hFFFF_FFFF_FFFF_F000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(1'b0, 64'h0, 64'h100, 64'h1000);
    send_request(1'b0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    // fill the table to exercise the full cases
    while (shadow_count < ara_pkg::MaxRanges)
      send_request(1'b1, 64'h5000_0000 + 64'(shadow_count) * 64'h100, 64'h10, 64'h0);
    send_request(1'b1, 64'h7000_0000, 64'h10, 64'h0);
    send_request(1'b0, 64'h0, 64'h10, 64'h10);
    send_request(1'b0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1);
  endtask

  // The table never empties, so random work runs on a full table; vary windows
  task automatic test_random(int n);
    logic [63:0] s, a;
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0)
        set_window($urandom_range(3) == 0 ? rand64() : 64'($urandom_range(15)) << 28,
                   $urandom_range(3) == 0 ? rand64() : 64'($urandom) << $urandom_range(8));
      busy_phase = (i % 500) > 400;
      idle_pct = busy_phase ? 0 : 27;
      case ($urandom_range(3))
        0: s = rand64();
        1: s = 64'($urandom_range(64));
        default: s = 64'(1) << $urandom_range(20);
      endcase
      case ($urandom_range(3))
        0: a = 64'h0;
        1: a = rand64();
        default: a = 64'(1) << $urandom_range(63);
      endcase
      if ($urandom_range(1)) send_request(1'b1, rand64(), s, a);
      else if ($urandom_range(3) == 0)
        send_request(1'b1, shadow_start[$urandom_range(shadow_count - 1)], s, a);
      else send_request(1'b0, rand64(), s, a);
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        rsp_hold = 1'b1;
        repeat (400) @(posedge clk);
        rsp_hold = 1'b0;
      end
      for (int i = 0; i < 20; i++) send_request(1'b0, 64'h0, 64'h0, 64'h0);
    join
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    req.valid = 1'b0; req.kind = 1'b0; req.request_base = '0;
    req.request_size = '0; req.alignment = '0;
    win_base = '0; win_size = '0; shadow_count = 0;
    errors = 0; sent = 0; received = 0; cycles = 0;
    rsp_hold = 1'b0; idle_pct = 27;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(1500);
    drain();
    $display("Covered %0d requests (directed, full-table, wraparound, random), %0d results.",
             sent, received);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
